// ===== rtl/lzbd_pkg.sv =====
// Shared constants and types for the LZ bit-stream decompressor.
`default_nettype none
package lzbd_pkg;
  localparam int HIST_AW = 14;
  localparam int HISTORY_DEPTH = 1 << HIST_AW;
  localparam int MAX_BURST = 64;
  localparam int BURST_AW = 6;
  localparam int BIT_BUFFER_BITS = 32;
  localparam int DIST_BITS = 13;
  localparam int DIST_BIAS = 3;
  localparam int MIN_LEN = 3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIST = 2'd1;
  localparam logic [1:0] ERR_OVFL = 2'd2;

  localparam logic ACT_PUSH = 1'b0;

  typedef enum logic [4:0] {
    PH_FLAG    = 5'b00001,
    PH_LITERAL = 5'b00010,
    PH_DISTANCE = 5'b00100,
    PH_LENGTH  = 5'b01000,
    PH_COPY    = 5'b10000
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DEC      = 5'b00010,
    S_COPYW    = 5'b00100,
    S_EMIT_RD  = 5'b01000,
    S_EMIT_OUT = 5'b10000
  } state_t;

  function automatic logic [3:0] len_field_bits(input logic [1:0] stage);
    case (stage)
      2'd0: len_field_bits = 4'd2;
      2'd1: len_field_bits = 4'd3;
      2'd2: len_field_bits = 4'd5;
      default: len_field_bits = 4'd8;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/lzbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lz_bitstream_decompressor.sv =====
// Top level of the LZ bit-stream decompressor.
//  channel | direction | payload
//  in_     | slave     | tdata: comp_byte, start_stream; tuser: action
//  out_    | master    | tdata: out_byte, copy_pending, stream_done, error_code;
//          |           | tuser: byte_valid; tlast: last_of_run
//  cfg_    | APB slave | register 0 output_length at byte address 0
// One item is taken, then decoded at one command step per cycle (a copy byte is a history
// RAM read, then a write). Results are collected in a burst RAM and sent afterwards, each
// read back from the burst RAM and then offered, so status holds for the whole item.
// The next item is taken only after the last result of the item has gone out.
// Reset (synchronous, rst_n low) clears all control state; the RAMs need no clearing.
`default_nettype none
module lz_bitstream_decompressor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] comp_byte, [8] start_stream
  input  wire logic [0:0]  in_tuser,   // [0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [7:0] out_byte, [8] copy_pending,
                                       // [9] stream_done, [11:10] error_code
  output logic      [0:0]  out_tuser,  // [0] byte_valid
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import lzbd_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [31:0] outlen_r;
  logic [BIT_BUFFER_BITS-1:0] buf_r, buf_nxt;
  logic [5:0] bc_r, bc_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic [13:0] dist_r, dist_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic done_r, done_nxt;
  logic [1:0] err_r, err_nxt;
  logic [6:0] nb_r, nb_nxt;
  logic [6:0] k_r, k_nxt;

  logic hist_we, hist_re, burst_we, burst_re;
  logic [HIST_AW-1:0] hist_raddr;
  logic [7:0] wbyte, hist_rdata, burst_rdata;

  logic in_acc, out_acc, cfg_wr;
  logic [3:0] sz;
  logic [7:0] fval, fmask;
  logic [32:0] rsum;
  logic [4:0] flag_idx;
  logic last_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? outlen_r : 32'd0;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_EMIT_OUT);
  assign out_acc = out_tvalid && out_tready;
  assign last_res = (nb_r == 7'd0) || (k_r == nb_r - 7'd1);
  assign out_tlast = last_res;
  assign out_tuser = (nb_r != 7'd0);
  assign out_tdata = {4'd0, err_r, done_r, (phase_r == PH_COPY) && (rem_r != 32'd0),
                      (nb_r != 7'd0) ? burst_rdata : 8'd0};

  assign sz = len_field_bits(stage_r);
  assign fmask = 8'((9'd1 << sz) - 9'd1);
  assign fval = 8'(buf_r >> (bc_r - 6'(sz))) & fmask;
  assign rsum = {1'b0, rem_r} + 33'(fval);
  assign flag_idx = 5'(bc_r - 6'd1);
  assign hist_raddr = wp_r - dist_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    buf_nxt = buf_r;
    bc_nxt = bc_r;
    stage_nxt = stage_r;
    dist_nxt = dist_r;
    rem_nxt = rem_r;
    prod_nxt = prod_r;
    wp_nxt = wp_r;
    done_nxt = done_r;
    err_nxt = err_r;
    nb_nxt = nb_r;
    k_nxt = k_r;
    hist_we = 1'b0;
    hist_re = 1'b0;
    burst_we = 1'b0;
    burst_re = 1'b0;
    wbyte = 8'(buf_r >> (bc_r - 6'd8));
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tdata[8]) begin
            phase_nxt = PH_FLAG;
            buf_nxt = '0;
            bc_nxt = '0;
            stage_nxt = '0;
            dist_nxt = '0;
            rem_nxt = '0;
            prod_nxt = '0;
            wp_nxt = '0;
            done_nxt = 1'b0;
          end
          err_nxt = ERR_NONE;
          if (in_tuser[0] == ACT_PUSH && !done_nxt) begin
            if (bc_nxt > 6'(BIT_BUFFER_BITS - 8)) begin
              err_nxt = ERR_OVFL;
            end else begin
              buf_nxt = {buf_nxt[BIT_BUFFER_BITS-9:0], in_tdata[7:0]};
              bc_nxt = bc_nxt + 6'd8;
            end
          end
          nb_nxt = '0;
          k_nxt = '0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_EMIT_RD;  // item ends unless a step continues below
        if (!done_r && nb_r != 7'(MAX_BURST)) begin
          case (phase_r)
            PH_COPY: begin
              hist_re = 1'b1;
              state_nxt = S_COPYW;
            end
            PH_FLAG: begin
              if (prod_r >= outlen_r) begin
                done_nxt = 1'b1;
              end else if (bc_r != 6'd0) begin
                phase_nxt = buf_r[flag_idx] ? PH_DISTANCE : PH_LITERAL;
                bc_nxt = bc_r - 6'd1;
                state_nxt = S_DEC;
              end
            end
            PH_LITERAL: begin
              if (bc_r >= 6'd8) begin
                hist_we = 1'b1;
                burst_we = 1'b1;
                wp_nxt = wp_r + 1'b1;
                prod_nxt = (prod_r == '1) ? prod_r : prod_r + 32'd1;
                nb_nxt = nb_r + 7'd1;
                bc_nxt = bc_r - 6'd8;
                phase_nxt = PH_FLAG;
                state_nxt = S_DEC;
              end
            end
            PH_DISTANCE: begin
              if (bc_r >= 6'(DIST_BITS)) begin
                dist_nxt = 14'(13'(buf_r >> (bc_r - 6'(DIST_BITS)))) + 14'(DIST_BIAS);
                bc_nxt = bc_r - 6'(DIST_BITS);
                rem_nxt = 32'(MIN_LEN);
                stage_nxt = '0;
                phase_nxt = PH_LENGTH;
                state_nxt = S_DEC;
              end
            end
            PH_LENGTH: begin
              if (bc_r >= 6'(sz)) begin
                bc_nxt = bc_r - 6'(sz);
                rem_nxt = rsum[32] ? '1 : rsum[31:0];
                state_nxt = S_DEC;
                if (fval == fmask) begin
                  if (stage_r != 2'd3) stage_nxt = stage_r + 2'd1;
                end else if (32'(dist_r) > prod_r) begin
                  rem_nxt = '0;
                  phase_nxt = PH_FLAG;
                  if (err_r == ERR_NONE) err_nxt = ERR_DIST;
                  state_nxt = S_EMIT_RD;
                end else begin
                  phase_nxt = PH_COPY;
                end
              end
            end
            default: state_nxt = S_EMIT_RD;
          endcase
        end
        if (state_nxt == S_EMIT_RD && nb_r == 7'd0 && nb_nxt == 7'd0) begin
          state_nxt = S_EMIT_OUT;  // status-only result, nothing to read back
        end
      end
      S_COPYW: begin
        wbyte = hist_rdata;
        hist_we = 1'b1;
        burst_we = 1'b1;
        wp_nxt = wp_r + 1'b1;
        prod_nxt = (prod_r == '1) ? prod_r : prod_r + 32'd1;
        nb_nxt = nb_r + 7'd1;
        rem_nxt = rem_r - 32'd1;
        if (rem_r == 32'd1) phase_nxt = PH_FLAG;
        state_nxt = S_DEC;
      end
      S_EMIT_RD: begin
        burst_re = 1'b1;
        state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_acc) begin
          if (last_res) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 7'd1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_FLAG;
      outlen_r <= '0;
      buf_r <= '0;
      bc_r <= '0;
      stage_r <= '0;
      dist_r <= '0;
      rem_r <= '0;
      prod_r <= '0;
      wp_r <= '0;
      done_r <= 1'b0;
      err_r <= ERR_NONE;
      nb_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (cfg_wr && cfg_paddr == 3'd0) outlen_r <= cfg_pwdata;
      buf_r <= buf_nxt;
      bc_r <= bc_nxt;
      stage_r <= stage_nxt;
      dist_r <= dist_nxt;
      rem_r <= rem_nxt;
      prod_r <= prod_nxt;
      wp_r <= wp_nxt;
      done_r <= done_nxt;
      err_r <= err_nxt;
      nb_r <= nb_nxt;
      k_r <= k_nxt;
    end
  end

  lzbd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(wp_r), .wdata(wbyte),
    .re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
  );

  lzbd_ram #(.WIDTH(8), .DEPTH(MAX_BURST)) u_burst (
    .clk(clk), .we(burst_we), .waddr(nb_r[BURST_AW-1:0]), .wdata(wbyte),
    .re(burst_re), .raddr(k_r[BURST_AW-1:0]), .rdata(burst_rdata)
  );
endmodule
`default_nettype wire

// ===== rtl/lzbd_checker.sv =====
// Port-level checks for the decompressor, bound to the top level.
`default_nettype none
module lzbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        out_tlast
);
  // a status-only transaction is always the last of its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast) else $error("status-only not last");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while results pending");

  a_decode_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid) else $error("result without decode cycle");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:10] != 2'd3) else $error("bad error code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && out_tvalid)
    else $error("stalled output changed");
endmodule

bind lz_bitstream_decompressor lzbd_checker u_lzbd_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the LZ bit-stream decompressor top level.
`timescale 1ns / 1ps
module tb_top;
  import lzbd_pkg::*;

  typedef struct {
    bit       act;
    bit [7:0] cbyte;
    bit       st;
  } comp_item_t;

  typedef struct {
    bit [7:0] data;
    bit       vld;
    bit       last;
    bit       pend;
    bit       done;
    bit [1:0] err;
  } dec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] comp_byte, [8] start_stream
  logic [0:0]  in_tuser = '0;   // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] out_byte, [8] copy_pending, [9] stream_done,
                                // [11:10] error_code
  logic [0:0]  out_tuser;       // [0] byte_valid
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] ADDR_OUT_LEN = 3'd0;

  lz_bitstream_decompressor dut (.*);

  always #5 clk = ~clk;

  // ---------------- decoder predictor ----------------
  bit [31:0] out_len_reg;
  bit [31:0] bit_buf;
  int        bit_cnt;
  phase_t    dec_phase;
  int        len_stage;
  bit [13:0] cp_dist;
  bit [31:0] cp_left;
  bit [31:0] produced;
  bit [7:0]  hist_mem [HISTORY_DEPTH];
  bit [13:0] wr_ptr;
  bit        done_flag;

  dec_result_t expected_q[$];
  comp_item_t  pending_items[$];
  int          n_items, n_results, n_mismatch, n_ovfl, n_dist, n_done;

  function automatic void clear_decoder();
    bit_buf = '0; bit_cnt = 0; dec_phase = PH_FLAG; len_stage = 0;
    cp_dist = '0; cp_left = '0; produced = '0; wr_ptr = '0; done_flag = 1'b0;
  endfunction

  function automatic bit [31:0] pull_bits(int n);
    bit [63:0] v;
    v = ({32'b0, bit_buf} >> (bit_cnt - n)) & ((64'd1 << n) - 1);
    bit_cnt -= n;
    return v[31:0];
  endfunction

  function automatic void write_hist(bit [7:0] x, ref bit [7:0] got[$]);
    hist_mem[wr_ptr] = x;
    wr_ptr++;
    if (produced != 32'hFFFF_FFFF) produced++;
    got.insert(got.size(), x);
  endfunction

  function automatic void decode_item(bit act, bit [7:0] cb, bit st);
    bit [7:0]    got[$];
    logic [1:0]  err;
    int          lw[4];
    int          sz, n;
    bit [31:0]   v;
    dec_result_t r;
    lw = '{2, 3, 5, 8};
    err = ERR_NONE;
    if (st) clear_decoder();
    if (act == ACT_PUSH && !done_flag) begin
      if (bit_cnt + 8 > BIT_BUFFER_BITS) err = ERR_OVFL;
      else begin
        bit_buf = {bit_buf[23:0], cb};
        bit_cnt += 8;
      end
    end
    while (got.size() < MAX_BURST && !done_flag) begin
      if (dec_phase == PH_COPY) begin
        write_hist(hist_mem[wr_ptr - cp_dist], got);
        cp_left--;
        if (cp_left == 0) dec_phase = PH_FLAG;
      end else if (dec_phase == PH_FLAG) begin
        if (produced >= out_len_reg) begin
          done_flag = 1'b1;
          break;
        end
        if (bit_cnt < 1) break;
        dec_phase = pull_bits(1) ? PH_DISTANCE : PH_LITERAL;
      end else if (dec_phase == PH_LITERAL) begin
        if (bit_cnt < 8) break;
        write_hist(8'(pull_bits(8)), got);
        dec_phase = PH_FLAG;
      end else if (dec_phase == PH_DISTANCE) begin
        if (bit_cnt < DIST_BITS) break;
        cp_dist = 14'(pull_bits(DIST_BITS) + DIST_BIAS);
        cp_left = MIN_LEN;
        len_stage = 0;
        dec_phase = PH_LENGTH;
      end else begin
        sz = lw[len_stage];
        if (bit_cnt < sz) break;
        v = pull_bits(sz);
        cp_left = (cp_left > 32'hFFFF_FFFF - v) ? 32'hFFFF_FFFF : cp_left + v;
        if (v == (32'd1 << sz) - 1) begin
          if (len_stage < 3) len_stage++;
        end else if ({18'b0, cp_dist} > produced) begin
          // copy reaches before the stream start: dropped
          cp_left = '0;
          dec_phase = PH_FLAG;
          if (err == ERR_NONE) err = ERR_DIST;
          break;
        end else dec_phase = PH_COPY;
      end
    end
    n = (got.size() > 0) ? got.size() : 1;
    for (int k = 0; k < n; k++) begin
      r.data = (got.size() > 0) ? got[k] : 8'h00;
      r.vld  = got.size() > 0;
      r.last = (k == n - 1);
      r.pend = (dec_phase == PH_COPY) && (cp_left != 0);
      r.done = done_flag;
      r.err  = err;
      expected_q.insert(expected_q.size(), r);
    end
    if (err == ERR_OVFL) n_ovfl++;
    if (err == ERR_DIST) n_dist++;
    if (done_flag) n_done++;
  endfunction

  // ---------------- handshake tracking, checking ----------------
  bit in_acc, out_acc;
  int cycles;

  function automatic void flag_mismatch(string what, int exp_v, int got_v);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    dec_result_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
    in_acc  <= rst_n && in_tvalid && in_tready;
    out_acc <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      n_items++;
      decode_item(in_tuser[0], in_tdata[7:0], in_tdata[8]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_q.size() == 0) flag_mismatch("unexpected transaction", 0, out_tdata);
      else begin
        e = expected_q.pop_front();
        if (out_tdata[7:0] != e.data) flag_mismatch("out_byte", e.data, out_tdata[7:0]);
        if (out_tuser[0] != e.vld) flag_mismatch("byte_valid", e.vld, out_tuser[0]);
        if (out_tlast != e.last) flag_mismatch("last_of_run", e.last, out_tlast);
        if (out_tdata[8] != e.pend) flag_mismatch("copy_pending", e.pend, out_tdata[8]);
        if (out_tdata[9] != e.done) flag_mismatch("stream_done", e.done, out_tdata[9]);
        if (out_tdata[11:10] != e.err) flag_mismatch("error_code", e.err, out_tdata[11:10]);
        if (out_tdata[15:12] != 4'b0) flag_mismatch("tdata pad", 0, out_tdata[15:12]);
      end
    end
  end

  // ---------------- sender ----------------
  bit send_idle_on, recv_idle_on;
  int send_gap, recv_gap;

  always @(negedge clk) begin
    comp_item_t it;
    if (!rst_n) in_tvalid <= 1'b0;
    else if (in_tvalid && !in_acc) begin
      // hold until taken
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap--;
    end else if (pending_items.size() > 0) begin
      it = pending_items.pop_front();
      in_tdata  <= {7'b0, it.st, it.cbyte};
      in_tuser  <= it.act;
      in_tvalid <= 1'b1;
      send_gap = send_idle_on ? $urandom_range(0, 16) : 0;
    end else in_tvalid <= 1'b0;
  end

  // ---------------- receiver ----------------
  int hold_req, hold_seen, hold_cnt;

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 600;
    end else if (hold_cnt > 0) hold_cnt--;
  end

  always @(negedge clk) begin
    if (!rst_n || hold_cnt > 0) out_tready <= 1'b0;
    else if (out_tready && !out_acc) begin
      // wait for the transaction
    end else if (recv_gap > 0) begin
      out_tready <= 1'b0;
      recv_gap--;
    end else begin
      out_tready <= 1'b1;
      recv_gap = recv_idle_on ? $urandom_range(0, 16) : 0;
    end
  end

  // ---------------- stream encoder ----------------
  bit      enc_bits[$];
  bit      enc_start;
  longint  enc_produced;

  function automatic void add_item(bit act, bit [7:0] cb);
    comp_item_t it;
    it.act = act; it.cbyte = cb; it.st = enc_start;
    enc_start = 1'b0;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void put_bits(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) enc_bits.insert(enc_bits.size(), v[i]);
  endfunction

  function automatic void flush_bytes(bit pad);
    bit [7:0] b;
    if (pad) while (enc_bits.size() % 8 != 0) enc_bits.insert(enc_bits.size(), 1'b0);
    while (enc_bits.size() >= 8) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], enc_bits.pop_front()};
      add_item(ACT_PUSH, b);
    end
  endfunction

  function automatic void add_drains(int n);
    for (int i = 0; i < n; i++) add_item(!ACT_PUSH, 8'($urandom()));
  endfunction

  function automatic void enc_literal(bit [7:0] b);
    put_bits(0, 1);
    put_bits(b, 8);
    enc_produced++;
  endfunction

  function automatic void enc_copy(int cdist, int len);
    int lw[4];
    int rem, sz, mx, st;
    lw = '{2, 3, 5, 8};
    put_bits(1, 1);
    put_bits(cdist - DIST_BIAS, DIST_BITS);
    rem = len - MIN_LEN;
    st = 0;
    forever begin
      sz = lw[st];
      mx = (1 << sz) - 1;
      if (rem < mx) begin
        put_bits(rem, sz);
        break;
      end
      put_bits(mx, sz);
      rem -= mx;
      if (st < 3) st++;
    end
    if (cdist <= enc_produced) enc_produced += len;
    flush_bytes(1'b0);
    add_drains(len / 64 + 1);
  endfunction

  function automatic void start_stream();
    enc_start = 1'b1;
    enc_produced = 0;
    enc_bits.delete();
  endfunction

  function automatic void random_stream(int ncmd);
    int d, len, top;
    start_stream();
    for (int c = 0; c < ncmd; c++) begin
      if (enc_produced < 3 || $urandom_range(0, 99) < 40) enc_literal(8'($urandom()));
      else begin
        top = (enc_produced > 8194) ? 8194 : int'(enc_produced);
        if ($urandom_range(0, 99) < 8) d = $urandom_range(top + 1, 8194);
        else if ($urandom_range(0, 99) < 80) d = $urandom_range(3, (top < 40) ? top : 40);
        else d = $urandom_range(3, top);
        len = ($urandom_range(0, 99) < 5) ? $urandom_range(40, 300) : $urandom_range(3, 20);
        enc_copy(d, len);
      end
      if ($urandom_range(0, 99) < 5) add_item(ACT_PUSH, 8'($urandom())); // noise byte
      flush_bytes(1'b0);
    end
    flush_bytes(1'b1);
    add_drains(2);
  endfunction

  // ---------------- config port ----------------
  task automatic cfg_write(bit [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_OUT_LEN; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    out_len_reg = val;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_q.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // ---------------- scenario ----------------
  initial begin
    bit [31:0] len_val;
    clear_decoder();
    out_len_reg = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: boundary literals, bad distance, overlapping copy, overflow
    cfg_write(32'hFFFF_FFFF);
    start_stream();
    add_item(!ACT_PUSH, 8'hA5);       // drain with start: status only
    enc_literal(8'h00);
    enc_literal(8'hFF);
    enc_copy(3, 3);                   // only two bytes out so far: rejected
    enc_literal(8'h55);
    enc_copy(3, 10);                  // overlapping copy
    flush_bytes(1'b0);
    put_bits(1, 1); put_bits(0, 13); put_bits(3, 2); put_bits(7, 3);
    put_bits(31, 5); put_bits(255, 8); put_bits(1, 8);  // length 300
    flush_bytes(1'b0);
    for (int i = 0; i < 5; i++) add_item(ACT_PUSH, 8'($urandom())); // fills the bit buffer
    add_drains(6);
    flush_bytes(1'b1);
    wait_idle();

    // directed: stop at the length, pushes after done, sticky done
    cfg_write(32'd5);
    start_stream();
    for (int i = 0; i < 4; i++) enc_literal(8'($urandom()));
    enc_copy(3, 4);                   // passes the length, still completes
    enc_literal(8'h81);
    flush_bytes(1'b1);
    add_item(ACT_PUSH, 8'hFF);
    wait_idle();
    cfg_write(32'd1000);
    add_drains(1);
    wait_idle();
    cfg_write(32'd0);
    start_stream();
    add_item(ACT_PUSH, 8'h00);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: len_val = 32'hFFFF_FFFF;
        1: len_val = $urandom_range(10, 120);
        2: len_val = 32'd1;
        default: len_val = $urandom();
      endcase
      cfg_write(len_val);
      send_idle_on = (ph % 3) != 0;
      recv_idle_on = (ph % 3) != 1;
      if (ph == 4) hold_req++;
      random_stream(ph == 2 ? 3 : 7);
      wait_idle();
    end

    $display("%0d items in, %0d results out; %0d overflow, %0d bad distance, %0d done",
             n_items, n_results, n_ovfl, n_dist, n_done);
    if (n_mismatch == 0) $display("[ OK ] regression clean");
    else begin
      $display("%0d mismatches", n_mismatch);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
